FILE: rtl/decimal_text_to_fixed_point_unit_macros.svh
// Assertion macros shared by the checker of the decimal text converter.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_UNIT_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DTF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dtf_pkg.sv
// Types and constants of the decimal text to fixed-point converter.
`default_nettype none

package dtf_pkg;

    // Width of the mantissa and exponent magnitudes.
    localparam int MAG_W = 60;
    // Width of the signed scale sum (exponent plus narrow counter terms).
    localparam int SCALE_W = 63;
    // Width of the scaling step counter.
    localparam int SCALE_CNT_W = 5;
    // Width of the decimals register.
    localparam int DEC_W = 5;
    // Width of the result amount.
    localparam int AMOUNT_W = 61;

    // Largest magnitude that is accepted, and its tenth.
    localparam logic [MAG_W-1:0] VALUE_BOUND = 60'd999999999999999999;
    localparam logic [MAG_W-1:0] BOUND_DIV10 = 60'd99999999999999999;
    // Scale exponents must stay below this.
    localparam int MAX_SCALE = 18;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;

    // Grammar position within the number text.
    typedef enum logic [3:0] {
        PH_START      = 4'd0,
        PH_SIGNED     = 4'd1,
        PH_LONE_ZERO  = 4'd2,
        PH_INT        = 4'd3,
        PH_POINT      = 4'd4,
        PH_FRAC       = 4'd5,
        PH_EXP_MARK   = 4'd6,
        PH_EXP_SIGNED = 4'd7,
        PH_EXP_DIGITS = 4'd8
    } phase_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_MANT = 3'd1,
        ST_EXP  = 3'd2,
        ST_SUM  = 3'd3,
        ST_CHK  = 3'd4,
        ST_MUL  = 3'd5,
        ST_DONE = 3'd6
    } state_t;

    // Decoded character class.
    typedef struct packed {
        logic       dig;
        logic [3:0] digit;
        logic       zero;
        logic       minus;
        logic       plus;
        logic       point;
        logic       emark;
    } char_class_t;

endpackage

`default_nettype wire

FILE: rtl/dtf_char_class.sv
// Character decoder: classifies one byte of the number text.
`default_nettype none

module dtf_char_class (
    input  wire logic [7:0]          char_code,
    output dtf_pkg::char_class_t     cls
);

    import dtf_pkg::*;

    logic [7:0] offset;

    // Digit value is the byte less the code of zero.
    assign offset = char_code - CH_ZERO;

    always_comb
    begin
        cls.dig   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        cls.digit = cls.dig ? offset[3:0] : 4'd0;
        cls.zero  = (char_code == CH_ZERO);
        cls.minus = (char_code == CH_MINUS);
        cls.plus  = (char_code == CH_PLUS);
        cls.point = (char_code == CH_POINT);
        cls.emark = (char_code == CH_E_LO) || (char_code == CH_E_UP);
    end

endmodule

`default_nettype wire

FILE: rtl/dtf_mul10.sv
// Shared arithmetic unit: multiply by ten, add a digit, and flag overflow.
`default_nettype none

module dtf_mul10 (
    input  wire logic [dtf_pkg::MAG_W-1:0] op,
    input  wire logic [3:0]                addend,
    output logic      [dtf_pkg::MAG_W-1:0] result,
    output logic                           over
);

    import dtf_pkg::*;

    logic [63:0] sum;

    // Ten times the operand as two shifted copies, plus the digit.
    assign sum = {1'b0, op, 3'b000} + {3'b000, op, 1'b0} + {60'd0, addend};

    // The step is refused when the operand exceeds a tenth of the bound.
    assign over   = (op > BOUND_DIV10);
    assign result = sum[MAG_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/decimal_text_to_fixed_point_unit.sv
// Top level of the decimal text to fixed-point converter.
//
// The input channel takes one character beat at a time (is_end, char_code);
// a beat with is_end high closes the number and produces exactly one result
// beat (ok, amount) on the output channel. Character beats produce nothing.
// The configuration channel writes the decimals register; it is always ready
// and must only be written while the block is idle.
// Steps: a nonzero mantissa digit that follows a nonzero digit makes one pass
// per deferred trailing zero plus one more through the shared multiply-by-ten
// unit, unless the bound stops it first; an exponent digit makes one pass there.
// An end beat runs through the sum, check (valid text only), scaling (scale 0 to 17
// only) and done states, one pass per decimal scaling step, before the result is
// in the output register. One shared multiply-by-ten unit serves all of these steps.
// The input is ready only while the sequencer is idle.
// A finished result waits in the output register; while the receiver stalls,
// character beats are still taken, and the next end beat holds in its final
// state until the register is free. Reset clears the parse state, empties the
// output register and sets decimals to 8; no clearing pass is needed.
`default_nettype none

module decimal_text_to_fixed_point_unit #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Character input channel.
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             is_end,
    input  wire logic [7:0]                       char_code,
    // Result output channel.
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  ok,
    output logic signed [dtf_pkg::AMOUNT_W-1:0]   amount,
    // Configuration write channel.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dtf_pkg::DEC_W-1:0]        cfg_data
);

    import dtf_pkg::*;

    localparam int NARROW_W = COUNTER_BITS + 2;

    // Sequencer and parse state.
    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [MAG_W-1:0]          mant_reg, mant_next;
    logic [MAG_W-1:0]          exp_reg, exp_next;
    logic [COUNTER_BITS-1:0]   pending_reg, pending_next;
    logic [COUNTER_BITS-1:0]   frac_reg, frac_next;
    logic                      neg_reg, neg_next;
    logic                      exp_neg_reg, exp_neg_next;
    logic                      failed_reg, failed_next;
    logic [3:0]                digit_reg, digit_next;
    logic [SCALE_W-1:0]        scale_reg, scale_next;
    logic [SCALE_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                      res_ok_reg, res_ok_next;
    logic [DEC_W-1:0]          decimals_reg;

    // Output register.
    logic                      out_valid_reg;
    logic                      ok_reg;
    logic [AMOUNT_W-1:0]       amount_reg;
    logic                      out_load;

    // Shared unit connections.
    logic [MAG_W-1:0]          unit_op;
    logic [3:0]                unit_addend;
    logic [MAG_W-1:0]          unit_res;
    logic                      unit_over;

    char_class_t               cls;
    logic signed [NARROW_W-1:0] narrow_sum;
    logic [SCALE_W-1:0]        narrow_ext;
    logic [SCALE_W-1:0]        exp_ext;
    logic [SCALE_W-1:0]        scale_sum;
    logic [AMOUNT_W-1:0]       mag_ext;
    logic [AMOUNT_W-1:0]       amount_calc;
    logic                      take_mant;
    logic                      take_exp;

    dtf_char_class u_class (
        .char_code (char_code),
        .cls       (cls)
    );

    dtf_mul10 u_mul10 (
        .op     (unit_op),
        .addend (unit_addend),
        .result (unit_res),
        .over   (unit_over)
    );

    // Narrow counter terms of the scale: trailing zeros less fraction digits plus decimals.
    assign narrow_sum = $signed({2'b00, pending_reg}) - $signed({2'b00, frac_reg})
                        + $signed({{(COUNTER_BITS - 3){1'b0}}, decimals_reg});
    assign narrow_ext = {{(SCALE_W - NARROW_W){narrow_sum[NARROW_W-1]}}, narrow_sum};
    assign exp_ext    = {{(SCALE_W - MAG_W){1'b0}}, exp_reg};
    assign scale_sum  = exp_neg_reg ? (narrow_ext - exp_ext) : (narrow_ext + exp_ext);

    // Signed result from the magnitude.
    assign mag_ext     = {1'b0, mant_reg};
    assign amount_calc = !res_ok_reg ? '0 : (neg_reg ? ('0 - mag_ext) : mag_ext);

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign amount    = $signed(amount_reg);

    // Sequencer state and parse registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_START;
            mant_reg    <= '0;
            exp_reg     <= '0;
            pending_reg <= '0;
            frac_reg    <= '0;
            neg_reg     <= 1'b0;
            exp_neg_reg <= 1'b0;
            failed_reg  <= 1'b0;
            res_ok_reg  <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            mant_reg    <= mant_next;
            exp_reg     <= exp_next;
            pending_reg <= pending_next;
            frac_reg    <= frac_next;
            neg_reg     <= neg_next;
            exp_neg_reg <= exp_neg_next;
            failed_reg  <= failed_next;
            res_ok_reg  <= res_ok_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Working registers that need no reset.
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        scale_reg <= scale_next;
    end

    // Decimals register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decimals_reg <= DEC_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            decimals_reg <= cfg_data;
        end
    end

    // Output register: valid control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ok_reg     <= res_ok_reg;
            amount_reg <= amount_calc;
        end
    end

    // Next state, parse updates and shared unit control.
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        mant_next    = mant_reg;
        exp_next     = exp_reg;
        pending_next = pending_reg;
        frac_next    = frac_reg;
        neg_next     = neg_reg;
        exp_neg_next = exp_neg_reg;
        failed_next  = failed_reg;
        digit_next   = digit_reg;
        scale_next   = scale_reg;
        cnt_next     = cnt_reg;
        res_ok_next  = res_ok_reg;
        unit_op      = mant_reg;
        unit_addend  = 4'd0;
        out_load     = 1'b0;
        take_mant    = 1'b0;
        take_exp     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_end)
                    begin
                        state_next = ST_SUM;
                    end
                    else if (!failed_reg)
                    begin
                        // Grammar step for one character.
                        case (phase_reg)
                            PH_START, PH_SIGNED:
                            begin
                                if ((phase_reg == PH_START) && cls.minus)
                                begin
                                    neg_next   = 1'b1;
                                    phase_next = PH_SIGNED;
                                end
                                else if (cls.zero)
                                begin
                                    phase_next = PH_LONE_ZERO;
                                end
                                else if (cls.dig)
                                begin
                                    take_mant  = 1'b1;
                                    phase_next = PH_INT;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                            PH_LONE_ZERO, PH_INT:
                            begin
                                if (cls.dig && (phase_reg == PH_INT))
                                begin
                                    take_mant = 1'b1;
                                end
                                else if (cls.point)
                                begin
                                    phase_next = PH_POINT;
                                end
                                else if (cls.emark)
                                begin
                                    phase_next = PH_EXP_MARK;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                            PH_POINT, PH_FRAC:
                            begin
                                if (cls.dig)
                                begin
                                    take_mant  = 1'b1;
                                    phase_next = PH_FRAC;
                                    if (&frac_reg)
                                    begin
                                        failed_next = 1'b1;
                                    end
                                    else
                                    begin
                                        frac_next = frac_reg + COUNTER_BITS'(1);
                                    end
                                end
                                else if (cls.emark && (phase_reg == PH_FRAC))
                                begin
                                    phase_next = PH_EXP_MARK;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                            PH_EXP_MARK:
                            begin
                                if (cls.plus)
                                begin
                                    phase_next = PH_EXP_SIGNED;
                                end
                                else if (cls.minus)
                                begin
                                    exp_neg_next = 1'b1;
                                    phase_next   = PH_EXP_SIGNED;
                                end
                                else if (cls.dig)
                                begin
                                    take_exp = 1'b1;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                            PH_EXP_SIGNED, PH_EXP_DIGITS:
                            begin
                                if (cls.dig)
                                begin
                                    take_exp = 1'b1;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                failed_next = 1'b1;
                            end
                        endcase

                        // Mantissa zeros wait; a first nonzero loads, others use the unit.
                        if (take_mant)
                        begin
                            if (cls.digit == 4'd0)
                            begin
                                if (&pending_reg)
                                begin
                                    failed_next = 1'b1;
                                end
                                else
                                begin
                                    pending_next = pending_reg + COUNTER_BITS'(1);
                                end
                            end
                            else if (mant_reg == '0)
                            begin
                                mant_next    = MAG_W'(cls.digit);
                                pending_next = '0;
                            end
                            else
                            begin
                                digit_next = cls.digit;
                                state_next = ST_MANT;
                            end
                        end

                        // Exponent digit takes one pass through the unit.
                        if (take_exp)
                        begin
                            digit_next = cls.digit;
                            state_next = ST_EXP;
                        end
                    end
                end
            end
            ST_MANT:
            begin
                // One multiply by ten per deferred zero, then one more that adds the digit.
                unit_op     = mant_reg;
                unit_addend = (pending_reg == '0) ? digit_reg : 4'd0;
                if (unit_over)
                begin
                    failed_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    mant_next = unit_res;
                    if (pending_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pending_next = pending_reg - COUNTER_BITS'(1);
                    end
                end
            end
            ST_EXP:
            begin
                unit_op     = exp_reg;
                unit_addend = digit_reg;
                if (unit_over)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    exp_next   = unit_res;
                    phase_next = PH_EXP_DIGITS;
                end
                state_next = ST_IDLE;
            end
            ST_SUM:
            begin
                // The text must be complete and free of errors.
                if (failed_reg ||
                    !(phase_reg inside {PH_INT, PH_LONE_ZERO, PH_FRAC, PH_EXP_DIGITS}))
                begin
                    res_ok_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    res_ok_next = 1'b1;
                    scale_next  = scale_sum;
                    state_next  = ST_CHK;
                end
            end
            ST_CHK:
            begin
                // Scale must lie in zero to seventeen.
                if (scale_reg[SCALE_W-1] || (scale_reg >= SCALE_W'(MAX_SCALE)))
                begin
                    res_ok_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cnt_next   = scale_reg[SCALE_CNT_W-1:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // Scale the mantissa one decade per cycle.
                unit_op = mant_reg;
                if (cnt_reg == '0)
                begin
                    if (mant_reg > VALUE_BOUND)
                    begin
                        res_ok_next = 1'b0;
                    end
                    state_next = ST_DONE;
                end
                else if (unit_over)
                begin
                    res_ok_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    mant_next = unit_res;
                    cnt_next  = cnt_reg - SCALE_CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_load     = 1'b1;
                    phase_next   = PH_START;
                    mant_next    = '0;
                    exp_next     = '0;
                    pending_next = '0;
                    frac_next    = '0;
                    neg_next     = 1'b0;
                    exp_neg_next = 1'b0;
                    failed_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/dtf_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
`default_nettype none

`include "decimal_text_to_fixed_point_unit_macros.svh"

module dtf_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           is_end,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic                           ok,
    input wire logic [dtf_pkg::AMOUNT_W-1:0]   amount
);

    import dtf_pkg::*;

    // A stalled result beat keeps its payload.
    `DTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ok) && $stable(amount), "result beat changed while stalled")

    // A failed parse always reports a zero amount.
    `DTF_ASSERT_NOW(a_fail_zero, out_valid && !ok, amount == '0, "failed result with nonzero amount")

    // A good result stays within the magnitude bound.
    `DTF_ASSERT_NOW(a_ok_range, out_valid && ok, ($signed(amount) <= $signed({1'b0, VALUE_BOUND})) && ($signed(amount) >= -$signed({1'b0, VALUE_BOUND})), "result amount out of range")

    // An end beat starts the finishing sequence, so the input closes next cycle.
    `DTF_ASSERT_NEXT(a_end_busy, in_valid && in_ready && is_end, !in_ready, "input ready right after an end beat")

endmodule

bind decimal_text_to_fixed_point_unit dtf_checker u_dtf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .is_end    (is_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .amount    (amount)
);

`default_nettype wire
